/* rtl/srp_pkg.sv */
// shared types, constants and helpers for the shelf rectangle packer
// no dependencies; used by every rtl file of the block
package srp_pkg;

  // geometry constants
  localparam int unsigned PAD         = 1;
  localparam int unsigned PAGE_MIN    = 256;
  localparam int unsigned PAGE_MAX    = 2048;
  localparam int unsigned PAGE_RESET  = 2048;

  // field widths
  localparam int unsigned SIDE_W  = 12;
  localparam int unsigned RECT_W  = 13;
  localparam int unsigned PADW_W  = 14;
  localparam int unsigned SUM_W   = 15;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned PGNUM_W = 2;

  // default parameter values
  localparam int unsigned PAGE_LIMIT_DEF  = 4;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // result status codes
  typedef enum logic [1:0] {
    STAT_PLACED  = 2'd0,
    STAT_TOO_BIG = 2'd1,
    STAT_NO_PAGE = 2'd2
  } status_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [RECT_W-1:0] h;
    logic [PADW_W-1:0] w_pad;
    logic [PADW_W-1:0] h_pad;
    logic              too_big;
    logic              new_batch;
  } item_t;

  // clamp the programmed page size into the legal range
  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] raw);
    logic [SIDE_W-1:0] res;
    if (raw < SIDE_W'(PAGE_MIN)) begin
      res = SIDE_W'(PAGE_MIN);
    end else if (raw > SIDE_W'(PAGE_MAX)) begin
      res = SIDE_W'(PAGE_MAX);
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

/* rtl/srp_front.sv */
// front end: accepts rectangles, adds padding and flags ones too big for a page
// depends on srp_pkg
module srp_front (
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [srp_pkg::RECT_W-1:0]  in_rect_width,
  input  logic [srp_pkg::RECT_W-1:0]  in_rect_height,
  input  logic                        in_new_batch,
  input  logic [srp_pkg::SIDE_W-1:0]  side,
  input  logic                        q_full,
  output logic                        q_push,
  output srp_pkg::item_t              q_item
);

  logic [srp_pkg::PADW_W-1:0] w_pad;
  logic [srp_pkg::PADW_W-1:0] h_pad;

  // padded extents
  assign w_pad = srp_pkg::PADW_W'(in_rect_width)  + srp_pkg::PADW_W'(srp_pkg::PAD);
  assign h_pad = srp_pkg::PADW_W'(in_rect_height) + srp_pkg::PADW_W'(srp_pkg::PAD);

  // classify and hand to the queue
  always_comb begin
    q_item.h         = in_rect_height;
    q_item.w_pad     = w_pad;
    q_item.h_pad     = h_pad;
    q_item.too_big   = (w_pad > srp_pkg::PADW_W'(side)) || (h_pad > srp_pkg::PADW_W'(side));
    q_item.new_batch = in_new_batch;
  end

  // transfer handshake
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

/* rtl/srp_queue.sv */
// small fifo of classified items between front and back
// depends on srp_pkg
module srp_queue #(
  parameter int unsigned DEPTH = srp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  srp_pkg::item_t push_item,
  input  logic           pop,
  output srp_pkg::item_t head_item,
  output logic           empty,
  output logic           full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  srp_pkg::item_t    slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign empty     = (count_r == '0);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign head_item = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* rtl/srp_back.sv */
// back end: shelf placement state, page advance and the result register
// depends on srp_pkg
module srp_back #(
  parameter int unsigned PAGE_LIMIT = srp_pkg::PAGE_LIMIT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [srp_pkg::SIDE_W-1:0]   side,
  input  srp_pkg::item_t               head_item,
  input  logic                         q_empty,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_status,
  output logic [srp_pkg::PGNUM_W-1:0]  out_page_number,
  output logic [srp_pkg::POS_W-1:0]    out_pos_x,
  output logic [srp_pkg::POS_W-1:0]    out_pos_y
);

  localparam int unsigned PG_W = (PAGE_LIMIT > 1) ? $clog2(PAGE_LIMIT) : 1;
  localparam int unsigned SW   = srp_pkg::SUM_W;

  // placement state
  logic [PG_W-1:0]            page_r, page_nxt;
  logic [srp_pkg::SIDE_W-1:0] top_r, top_nxt;
  logic [srp_pkg::RECT_W-1:0] tall_r, tall_nxt;
  logic [srp_pkg::RECT_W-1:0] col_r, col_nxt;
  logic                       exh_r, exh_nxt;

  // result register
  logic                       out_valid_r, out_valid_nxt;
  srp_pkg::status_t           status_r, status_nxt;
  logic [PG_W-1:0]            rpage_r, rpage_nxt;
  logic [srp_pkg::POS_W-1:0]  x_r, x_nxt;
  logic [srp_pkg::POS_W-1:0]  y_r, y_nxt;

  // working values
  logic [PG_W-1:0]            b_page;
  logic [SW-1:0]              b_top, b_tall, b_col;
  logic                       b_exh;
  logic                       across;
  logic [SW-1:0]              top2, col2, tall2, hext;
  logic                       down_ok, place_here, last_page;
  logic [PG_W+1:0]            rpage_ext;

  assign q_pop = !q_empty && (!out_valid_r || !out_stall);

  // placement decision for the item at the queue head
  always_comb begin
    b_page = head_item.new_batch ? '0 : page_r;
    b_top  = head_item.new_batch ? '0 : SW'(top_r);
    b_tall = head_item.new_batch ? '0 : SW'(tall_r);
    b_col  = head_item.new_batch ? '0 : SW'(col_r);
    b_exh  = head_item.new_batch ? 1'b0 : exh_r;
    hext   = SW'(head_item.h);

    across = (b_col + SW'(head_item.w_pad)) > SW'(side);
    top2   = across ? (b_top + b_tall + SW'(srp_pkg::PAD)) : b_top;
    col2   = across ? '0 : b_col;
    tall2  = across ? '0 : b_tall;

    down_ok    = (top2 + SW'(head_item.h_pad)) <= SW'(side);
    place_here = !head_item.too_big && down_ok;
    last_page  = (b_page == PG_W'(PAGE_LIMIT - 1));

    page_nxt   = page_r;
    top_nxt    = top_r;
    tall_nxt   = tall_r;
    col_nxt    = col_r;
    exh_nxt    = exh_r;
    status_nxt = status_r;
    rpage_nxt  = rpage_r;
    x_nxt      = x_r;
    y_nxt      = y_r;

    if (q_pop) begin
      page_nxt   = b_page;
      top_nxt    = b_top[srp_pkg::SIDE_W-1:0];
      tall_nxt   = b_tall[srp_pkg::RECT_W-1:0];
      col_nxt    = b_col[srp_pkg::RECT_W-1:0];
      exh_nxt    = b_exh;
      status_nxt = srp_pkg::STAT_NO_PAGE;
      rpage_nxt  = '0;
      x_nxt      = '0;
      y_nxt      = '0;
      if (b_exh) begin
        status_nxt = srp_pkg::STAT_NO_PAGE;
      end else if (place_here) begin
        status_nxt = srp_pkg::STAT_PLACED;
        rpage_nxt  = b_page;
        x_nxt      = col2[srp_pkg::POS_W-1:0];
        y_nxt      = top2[srp_pkg::POS_W-1:0];
        col_nxt    = srp_pkg::RECT_W'(col2 + SW'(head_item.w_pad));
        top_nxt    = top2[srp_pkg::SIDE_W-1:0];
        tall_nxt   = (hext > tall2) ? head_item.h : tall2[srp_pkg::RECT_W-1:0];
      end else if (last_page) begin
        exh_nxt    = 1'b1;
        status_nxt = srp_pkg::STAT_NO_PAGE;
      end else begin
        // fresh page; an item that passed the size check always lands at its corner
        page_nxt = b_page + 1'b1;
        top_nxt  = '0;
        if (head_item.too_big) begin
          status_nxt = srp_pkg::STAT_TOO_BIG;
          tall_nxt   = '0;
          col_nxt    = '0;
        end else begin
          status_nxt = srp_pkg::STAT_PLACED;
          rpage_nxt  = b_page + 1'b1;
          tall_nxt   = head_item.h;
          col_nxt    = srp_pkg::RECT_W'(head_item.w_pad);
        end
      end
    end
  end

  // output valid tracking
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r      <= '0;
      top_r       <= '0;
      tall_r      <= '0;
      col_r       <= '0;
      exh_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      page_r      <= page_nxt;
      top_r       <= top_nxt;
      tall_r      <= tall_nxt;
      col_r       <= col_nxt;
      exh_r       <= exh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    rpage_r  <= rpage_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
  end

  assign rpage_ext       = {2'b00, rpage_r};
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_page_number = rpage_ext[srp_pkg::PGNUM_W-1:0];
  assign out_pos_x       = x_r;
  assign out_pos_y       = y_r;

endmodule

/* rtl/shelf_rectangle_packer.sv */
// a taken rectangle is written into the queue; its result is then registered in the back end's result register
// the back end takes one rectangle per cycle from the queue unless the output stalls; placement is combinational
// a queue (four entries by default) lets the input keep taking rectangles while a result waits
// reset (synchronous, rst_n low): empty queue, empty first page, page size 2048
// top level of the shelf rectangle packer; depends on srp_pkg, srp_front, srp_queue, srp_back
module shelf_rectangle_packer #(
  parameter int unsigned PAGE_LIMIT  = srp_pkg::PAGE_LIMIT_DEF,
  parameter int unsigned QUEUE_DEPTH = srp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [srp_pkg::SIDE_W-1:0]   cfg_page_size,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [srp_pkg::RECT_W-1:0]   in_rect_width,
  input  logic [srp_pkg::RECT_W-1:0]   in_rect_height,
  input  logic                         in_new_batch,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_status,
  output logic [srp_pkg::PGNUM_W-1:0]  out_page_number,
  output logic [srp_pkg::POS_W-1:0]    out_pos_x,
  output logic [srp_pkg::POS_W-1:0]    out_pos_y
);

  logic [srp_pkg::SIDE_W-1:0] page_size_r;
  logic [srp_pkg::SIDE_W-1:0] side;
  logic                       q_push, q_pop, q_empty, q_full;
  srp_pkg::item_t             q_in_item, q_head_item;

  // page size register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_size_r <= srp_pkg::SIDE_W'(srp_pkg::PAGE_RESET);
    end else if (cfg_valid && cfg_ready) begin
      page_size_r <= cfg_page_size;
    end
  end

  assign side = srp_pkg::clamp_side(page_size_r);

  srp_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_new_batch   (in_new_batch),
    .side           (side),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_in_item)
  );

  srp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .pop       (q_pop),
    .head_item (q_head_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  srp_back #(
    .PAGE_LIMIT (PAGE_LIMIT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .side            (side),
    .head_item       (q_head_item),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_page_number (out_page_number),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y)
  );

endmodule

/* rtl/srp_checker.sv */
// port-level checks for the shelf rectangle packer, attached by bind
// depends on srp_pkg and the top level shelf_rectangle_packer
module srp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [1:0]                   out_status,
  input logic [srp_pkg::PGNUM_W-1:0]  out_page_number,
  input logic [srp_pkg::POS_W-1:0]    out_pos_x,
  input logic [srp_pkg::POS_W-1:0]    out_pos_y
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_page_number) && $stable(out_pos_x) && $stable(out_pos_y))
    else $error("stalled result changed");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // unplaced rectangles carry a zero position
  a_unplaced_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != srp_pkg::STAT_PLACED) |->
      (out_page_number == '0) && (out_pos_x == '0) && (out_pos_y == '0))
    else $error("unplaced result with nonzero position");

  // status stays within its codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == srp_pkg::STAT_PLACED) ||
      (out_status == srp_pkg::STAT_TOO_BIG) || (out_status == srp_pkg::STAT_NO_PAGE))
    else $error("bad status code");

endmodule

bind shelf_rectangle_packer srp_checker u_srp_checker (.*);
